// File: rtl/core/rtid_pkg.sv
// ----------------------------------------------------------------------------
// rtid_pkg
// Shared types and codes for the row table insert/delete core: sequencer
// states, operation modes, result status codes and stream field widths.
// ----------------------------------------------------------------------------
package rtid_pkg;

  // Field widths of the stream items and the config register
  localparam int MODE_W      = 2;
  localparam int ROW_IDX_W   = 7;
  localparam int COL_IDX_W   = 6;
  localparam int CHAR_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int COLS_W      = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Operation modes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_STAGED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;

  // Reset value of the column count register
  localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_FINISH,
    ST_READ,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/core/row_table_insert_delete_core.sv
// ----------------------------------------------------------------------------
// row_table_insert_delete_core
// Ordered table of fixed-width character rows kept in one row-wide RAM.
// Rows are staged one character per item and committed on the last item;
// insert and delete move the following rows one row per cycle.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata (mode,row,col,char), s_tlast
//  m_*      out  m_tvalid/m_tready  m_tdata (status,read_char,rows_in_use)
//  cfg_*    in   cfg_valid/cfg_ready cfg_data (cols_in_use)
//
// One item at a time. Insert and delete move up to MAX_ROWS - 1 rows through
// the single row-wide RAM port pair, with reads and writes overlapping.
// Reset clears the row count, staged count and column count (to 64); the
// RAM holds no reset state, no clearing pass. A full output register holds
// the core in its result state, so it blocks the next item from being taken
// until the result hand-off completes.
// ----------------------------------------------------------------------------
module row_table_insert_delete_core
  import rtid_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // mode[1:0], row_index[8:2], col_index[14:9], char_value[22:15], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,   // last_char
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // status[1:0], read_char[9:2], rows_in_use[16:10], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [COLS_W-1:0]      cfg_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SCW   = $clog2(MAX_COLS + 2);
  localparam int ROWW  = MAX_COLS * CHAR_W;
  localparam int CMPW  = (RCW > ROW_IDX_W) ? RCW : ROW_IDX_W;
  localparam int SCMPW = (SCW > COLS_W) ? SCW : COLS_W;

  // Control state
  state_t           state, state_next;
  logic [RCW-1:0]   row_count;
  logic [SCW-1:0]   staged_count;
  logic [COLS_W-1:0] cols_in_use;
  logic [RCW-1:0]   move_cnt;
  logic             rd_pend;

  // Latched item and datapath registers
  logic [MODE_W-1:0]    mode_q;
  logic [ROW_IDX_W-1:0] row_q;
  logic [COL_IDX_W-1:0] col_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;
  logic [CHAR_W-1:0]    stage_row [MAX_COLS];
  logic [RW-1:0]        cur_row;
  logic [RW-1:0]        dst_row;
  logic [STATUS_W-1:0]  res_status;
  logic [CHAR_W-1:0]    res_char;

  // RAM port signals
  logic             mem_we, mem_re;
  logic [RW-1:0]    mem_waddr, mem_raddr;
  logic [ROWW-1:0]  mem_wdata, mem_rdata;

  // Decode
  logic             in_accept, out_load;
  logic             is_row_op, shift_up;
  logic [SCW-1:0]   staged_inc;
  logic             row_le, row_lt, table_full;
  logic             commit_ok, del_ok, rd_ok;
  logic [RCW-1:0]   ins_moves, del_moves;
  logic [ROWW-1:0]  stage_flat;
  logic [CHAR_W-1:0] rd_byte;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign out_load  = (state == ST_RESULT) && (!m_tvalid || m_tready);

  // Checks on the latched item
  assign is_row_op  = (mode_q == MODE_APPEND) || (mode_q == MODE_INSERT);
  assign shift_up   = (mode_q == MODE_INSERT);
  assign staged_inc = (int'(staged_count) < MAX_COLS) ? SCW'(staged_count + 1'b1)
                                                      : SCW'(MAX_COLS + 1);
  assign row_le     = CMPW'(row_q) <= CMPW'(row_count);
  assign row_lt     = CMPW'(row_q) <  CMPW'(row_count);
  assign table_full = int'(row_count) >= MAX_ROWS;
  assign commit_ok  = !table_full && (SCMPW'(staged_inc) == SCMPW'(cols_in_use))
                      && !(shift_up && !row_le);
  assign del_ok     = row_lt;
  assign rd_ok      = row_lt && ({1'b0, col_q} < cols_in_use)
                      && (int'(col_q) < MAX_COLS);
  assign ins_moves  = RCW'(CMPW'(row_count) - CMPW'(row_q));
  assign del_moves  = RCW'(CMPW'(row_count) - CMPW'(row_q) - 1'b1);

  // Staging buffer as one row-wide word
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      stage_flat[i*CHAR_W +: CHAR_W] = stage_row[i];
    end
  end

  // Column select on the row read back
  always_comb begin
    rd_byte = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (CW'(col_q) == CW'(i)) begin
        rd_byte = mem_rdata[i*CHAR_W +: CHAR_W];
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (mode_q)
          MODE_APPEND, MODE_INSERT: begin
            if (!last_q || !commit_ok) state_next = ST_RESULT;
            else if (shift_up && ins_moves != '0) state_next = ST_SHIFT;
            else state_next = ST_FINISH;
          end
          MODE_DELETE: begin
            if (!del_ok) state_next = ST_RESULT;
            else if (del_moves != '0) state_next = ST_SHIFT;
            else state_next = ST_FINISH;
          end
          default: begin
            state_next = rd_ok ? ST_READ : ST_RESULT;
          end
        endcase
      end
      ST_SHIFT: begin
        if (move_cnt == '0 && !rd_pend) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_RESULT;
      ST_READ:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and RAM port controls
  always_comb begin
    s_tready  = (state == ST_IDLE);
    mem_re    = 1'b0;
    mem_raddr = RW'(row_q);
    mem_we    = 1'b0;
    mem_waddr = dst_row;
    mem_wdata = mem_rdata;
    case (state)
      ST_EXEC: begin
        mem_re = (mode_q == MODE_READ) && rd_ok;
      end
      ST_SHIFT: begin
        mem_re    = (move_cnt != '0);
        mem_raddr = cur_row;
        mem_we    = rd_pend;
      end
      ST_FINISH: begin
        mem_we    = is_row_op;
        mem_waddr = shift_up ? RW'(row_q) : RW'(row_count);
        mem_wdata = stage_flat;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row_count    <= '0;
      staged_count <= '0;
      cols_in_use  <= COLS_RESET;
      move_cnt     <= '0;
      rd_pend      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        cols_in_use <= cfg_data;
      end
      case (state)
        ST_EXEC: begin
          if (is_row_op) begin
            staged_count <= last_q ? '0 : staged_inc;
          end
          move_cnt <= shift_up ? ins_moves : del_moves;
          rd_pend  <= 1'b0;
        end
        ST_SHIFT: begin
          if (move_cnt != '0) move_cnt <= move_cnt - 1'b1;
          rd_pend <= (move_cnt != '0);
        end
        ST_FINISH: begin
          row_count <= is_row_op ? row_count + 1'b1 : row_count - 1'b1;
        end
        default: begin
          rd_pend <= rd_pend;
        end
      endcase
      // output register
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q <= s_tdata[1:0];
      row_q  <= s_tdata[8:2];
      col_q  <= s_tdata[14:9];
      char_q <= s_tdata[22:15];
      last_q <= s_tlast;
    end
    case (state)
      ST_EXEC: begin
        if (is_row_op && int'(staged_count) < MAX_COLS) begin
          stage_row[CW'(staged_count)] <= char_q;
        end
        res_char <= '0;
        if (is_row_op) begin
          res_status <= !last_q ? STAT_STAGED : (commit_ok ? STAT_DONE : STAT_REJECT);
        end else if (mode_q == MODE_DELETE) begin
          res_status <= del_ok ? STAT_DONE : STAT_REJECT;
        end else begin
          res_status <= rd_ok ? STAT_DONE : STAT_REJECT;
        end
        cur_row <= shift_up ? RW'(row_count - 1'b1) : RW'(CMPW'(row_q) + 1'b1);
      end
      ST_SHIFT: begin
        // issue one row move per cycle, write lands in the following cycle
        if (move_cnt != '0) begin
          dst_row <= shift_up ? cur_row + 1'b1 : cur_row - 1'b1;
          cur_row <= shift_up ? cur_row - 1'b1 : cur_row + 1'b1;
        end
      end
      ST_READ: begin
        res_char <= rd_byte;
      end
      default: begin
        res_char <= res_char;
      end
    endcase
    if (out_load) begin
      m_tdata <= {7'd0, 7'(row_count), res_char, res_status};
    end
  end

  // Row table storage
  rtid_ram #(
    .WIDTH (ROWW),
    .DEPTH (MAX_ROWS)
  ) u_table_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: rtl/core/rtid_ram.sv
// ----------------------------------------------------------------------------
// rtid_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rtid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/rtid_checker.sv
// ----------------------------------------------------------------------------
// rtid_checker
// Port-level checks for the row table core, bound to the top level.
// ----------------------------------------------------------------------------
module rtid_checker
  import rtid_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready
);

  // One item in flight: input closes right after an item is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Only a completed read returns a character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != STAT_DONE) |-> m_tdata[9:2] == 8'd0)
    else $error("character returned without a completed read");

  // Row count never beyond table depth
  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (MAX_ROWS > 127) || (m_tdata[16:10] <= 7'(MAX_ROWS)))
    else $error("row count beyond table depth");

  // No result right out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind row_table_insert_delete_core rtid_checker #(
  .MAX_ROWS (MAX_ROWS)
) u_rtid_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// File: tb/row_table_insert_delete_core_tb.sv
// ----------------------------------------------------------------------------
// row_table_insert_delete_core_tb
// Self-checking bench for the row table core. A directed table covers the
// reset state, edge fields, every mode and the reject cases. Random phases
// follow at several column counts: well-formed rows, inserts, deletes and
// reads with some noise, a full table, overlong rows, and a long output stall.
// Results are checked field by field against typed steps or an in-bench model.
// ----------------------------------------------------------------------------
module row_table_insert_delete_core_tb;
  import rtid_pkg::*;

  localparam int MAX_ROWS      = 64;
  localparam int MAX_COLS      = 64;
  localparam int GAP_MAX       = 17;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 80;
  localparam int N_DIR         = 25;

  // one input item
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [CHAR_W-1:0]    ch;
    logic                 last;
  } table_op_t;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CHAR_W-1:0]    rd;
    logic [ROW_IDX_W-1:0] rows;
  } table_res_t;

  // directed step: a column count write or an item with an optional typed result
  typedef struct packed {
    logic                 is_cfg;
    logic [COLS_W-1:0]    cfg_val;
    logic [MODE_W-1:0]    mode;
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [CHAR_W-1:0]    ch;
    logic                 last;
    logic                 typed;
    logic [STATUS_W-1:0]  st;
    logic [CHAR_W-1:0]    rd;
    logic [ROW_IDX_W-1:0] rows;
  } dir_step_t;

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [COLS_W-1:0]      cfg_data;
  logic                   cfg_valid;
  logic                   cfg_ready;

  row_table_insert_delete_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_data (cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  // Table model state; known bits mark entries that were ever written
  logic [CHAR_W-1:0] tbl_mem    [MAX_ROWS][MAX_COLS];
  bit                tbl_known  [MAX_ROWS][MAX_COLS];
  logic [CHAR_W-1:0] stage_buf  [MAX_COLS];
  bit                stage_known[MAX_COLS];
  int unsigned       row_total;
  int unsigned       staged_len;
  int unsigned       cols_cfg;

  table_res_t result_q[$];

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  int err_count;
  int quiet_cycles;
  int n_items, n_results, n_done, n_reject, n_staged, n_cfg, n_holds, peak_rows;

  // Directed steps, in order
  dir_step_t dir_tab [N_DIR] = '{
    '{1'b0, 7'd0, MODE_DELETE, 7'd0,  6'd0,  8'h00, 1'b0, 1'b1, STAT_REJECT, 8'h00, 7'd0},
    '{1'b0, 7'd0, MODE_READ,   7'd0,  6'd0,  8'h00, 1'b0, 1'b1, STAT_REJECT, 8'h00, 7'd0},
    '{1'b0, 7'd0, MODE_APPEND, 7'd0,  6'd0,  8'h11, 1'b1, 1'b1, STAT_REJECT, 8'h00, 7'd0},
    '{1'b1, 7'd1, MODE_APPEND, 7'd0,  6'd0,  8'h00, 1'b0, 1'b0, STAT_STAGED, 8'h00, 7'd0},
    '{1'b0, 7'd0, MODE_APPEND, 7'd64, 6'd63, 8'hFF, 1'b1, 1'b1, STAT_DONE,   8'h00, 7'd1},
    '{1'b0, 7'd0, MODE_APPEND, 7'd0,  6'd0,  8'h00, 1'b1, 1'b1, STAT_DONE,   8'h00, 7'd2},
    '{1'b0, 7'd0, MODE_INSERT, 7'd0,  6'd17, 8'hA5, 1'b1, 1'b1, STAT_DONE,   8'h00, 7'd3},
    '{1'b0, 7'd0, MODE_INSERT, 7'd4,  6'd0,  8'h3C, 1'b1, 1'b1, STAT_REJECT, 8'h00, 7'd3},
    '{1'b0, 7'd0, MODE_READ,   7'd0,  6'd0,  8'hFF, 1'b1, 1'b1, STAT_DONE,   8'hA5, 7'd3},
    '{1'b0, 7'd0, MODE_READ,   7'd1,  6'd0,  8'h00, 1'b0, 1'b1, STAT_DONE,   8'hFF, 7'd3},
    '{1'b0, 7'd0, MODE_READ,   7'd2,  6'd63, 8'h00, 1'b0, 1'b1, STAT_REJECT, 8'h00, 7'd3},
    '{1'b0, 7'd0, MODE_READ,   7'd64, 6'd0,  8'h00, 1'b0, 1'b1, STAT_REJECT, 8'h00, 7'd3},
    '{1'b0, 7'd0, MODE_INSERT, 7'd3,  6'd0,  8'h5A, 1'b1, 1'b1, STAT_DONE,   8'h00, 7'd4},
    '{1'b0, 7'd0, MODE_DELETE, 7'd4,  6'd0,  8'h00, 1'b0, 1'b1, STAT_REJECT, 8'h00, 7'd4},
    '{1'b0, 7'd0, MODE_DELETE, 7'd0,  6'd0,  8'h00, 1'b1, 1'b1, STAT_DONE,   8'h00, 7'd3},
    '{1'b0, 7'd0, MODE_READ,   7'd0,  6'd0,  8'h00, 1'b0, 1'b1, STAT_DONE,   8'hFF, 7'd3},
    '{1'b0, 7'd0, MODE_APPEND, 7'd0,  6'd0,  8'h33, 1'b0, 1'b1, STAT_STAGED, 8'h00, 7'd3},
    '{1'b0, 7'd0, MODE_INSERT, 7'd1,  6'd0,  8'h44, 1'b1, 1'b1, STAT_REJECT, 8'h00, 7'd3},
    '{1'b1, 7'd2, MODE_APPEND, 7'd0,  6'd0,  8'h00, 1'b0, 1'b0, STAT_STAGED, 8'h00, 7'd0},
    // mixed modes: append character, then insert on the last one
    '{1'b0, 7'd0, MODE_APPEND, 7'd9,  6'd5,  8'h33, 1'b0, 1'b0, STAT_STAGED, 8'h00, 7'd0},
    '{1'b0, 7'd0, MODE_INSERT, 7'd1,  6'd0,  8'h44, 1'b1, 1'b0, STAT_STAGED, 8'h00, 7'd0},
    '{1'b0, 7'd0, MODE_READ,   7'd1,  6'd1,  8'h00, 1'b0, 1'b1, STAT_DONE,   8'h44, 7'd4},
    '{1'b0, 7'd0, MODE_READ,   7'd1,  6'd2,  8'h00, 1'b0, 1'b1, STAT_REJECT, 8'h00, 7'd4},
    // zero column count rejects every commit
    '{1'b1, 7'd0, MODE_APPEND, 7'd0,  6'd0,  8'h00, 1'b0, 1'b0, STAT_STAGED, 8'h00, 7'd0},
    '{1'b0, 7'd0, MODE_APPEND, 7'd0,  6'd0,  8'h77, 1'b1, 1'b1, STAT_REJECT, 8'h00, 7'd4}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Table model: applies one accepted item and returns its result
  function automatic table_res_t table_apply(table_op_t op);
    table_res_t res;
    bit         ok;
    int         r;
    int         c;
    int         dest;
    res = '0;
    if (op.mode == MODE_APPEND || op.mode == MODE_INSERT) begin
      if (staged_len < MAX_COLS) begin
        stage_buf[staged_len]   = op.ch;
        stage_known[staged_len] = 1'b1;
        staged_len++;
      end else begin
        staged_len = MAX_COLS + 1;
      end
      if (op.last) begin
        ok = (row_total < MAX_ROWS) && (staged_len == cols_cfg);
        if (op.mode == MODE_INSERT && op.row > row_total) ok = 1'b0;
        if (ok) begin
          dest = row_total;
          if (op.mode == MODE_INSERT) begin
            // open a gap at the insert position
            for (r = row_total; r > op.row; r--) begin
              for (c = 0; c < MAX_COLS; c++) begin
                tbl_mem[r][c]   = tbl_mem[r-1][c];
                tbl_known[r][c] = tbl_known[r-1][c];
              end
            end
            dest = op.row;
          end
          for (c = 0; c < MAX_COLS; c++) begin
            tbl_mem[dest][c]   = stage_buf[c];
            tbl_known[dest][c] = stage_known[c];
          end
          row_total++;
          res.status = STAT_DONE;
        end else begin
          res.status = STAT_REJECT;
        end
        staged_len = 0;
      end else begin
        res.status = STAT_STAGED;
      end
    end else if (op.mode == MODE_DELETE) begin
      if (op.row < row_total) begin
        // close the gap left by the deleted row
        for (r = op.row; r + 1 < row_total; r++) begin
          for (c = 0; c < MAX_COLS; c++) begin
            tbl_mem[r][c]   = tbl_mem[r+1][c];
            tbl_known[r][c] = tbl_known[r+1][c];
          end
        end
        row_total--;
        res.status = STAT_DONE;
      end else begin
        res.status = STAT_REJECT;
      end
    end else begin
      if (op.row < row_total && op.col < cols_cfg) begin
        res.rd     = tbl_mem[op.row][op.col];
        res.status = STAT_DONE;
      end else begin
        res.status = STAT_REJECT;
      end
    end
    res.rows = row_total[ROW_IDX_W-1:0];
    if (row_total > peak_rows) peak_rows = row_total;
    return res;
  endfunction

  function automatic table_op_t make_op(logic [MODE_W-1:0] mode, logic [ROW_IDX_W-1:0] row,
                                        logic [COL_IDX_W-1:0] col, logic [CHAR_W-1:0] ch,
                                        logic last);
    table_op_t op;
    op.mode = mode;
    op.row  = row;
    op.col  = col;
    op.ch   = ch;
    op.last = last;
    return op;
  endfunction

  // Steer a read that would hit a never-written entry to column 0,
  // which every committed row holds
  function automatic logic [COL_IDX_W-1:0] safe_col(logic [ROW_IDX_W-1:0] row,
                                                    logic [COL_IDX_W-1:0] col);
    if (row < row_total && col < cols_cfg && !tbl_known[row][col]) return '0;
    return col;
  endfunction

  function automatic void note_mismatch(string what, table_res_t want, table_res_t got);
    err_count++;
    if (err_count <= 10)
      $display("tb: %s: exp status=%0d char=%02h rows=%0d, got status=%0d char=%02h rows=%0d",
               what, want.status, want.rd, want.rows, got.status, got.rd, got.rows);
  endfunction

  // Offer one item after a random gap; predict once it is taken
  task automatic send_op(input table_op_t op, input bit typed, input table_res_t want);
    int         gap;
    table_res_t got;
    gap = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {1'b0, op.ch, op.col, op.row, op.mode};
    s_tlast  <= op.last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = table_apply(op);
    result_q.push_back(typed ? want : got);
    n_items++;
  endtask

  // One row of len characters; the mode of the last one decides the commit
  task automatic send_row(input logic [MODE_W-1:0] final_mode, input int len,
                          input logic [ROW_IDX_W-1:0] at_row, input bit mixed);
    int          i;
    table_op_t   op;
    for (i = 0; i < len; i++) begin
      op.mode = final_mode;
      if (mixed) op.mode = $urandom_range(0, 1) ? MODE_INSERT : MODE_APPEND;
      op.row  = 7'($urandom_range(0, MAX_ROWS));
      op.col  = 6'($urandom_range(0, MAX_COLS - 1));
      op.ch   = 8'($urandom_range(0, 255));
      op.last = (i == len - 1);
      if (op.last) begin
        op.mode = final_mode;
        op.row  = at_row;
      end
      send_op(op, 1'b0, '0);
    end
  endtask

  // Hold the input side until every result is back, then let the core settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cols(input logic [COLS_W-1:0] val);
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cols_cfg = 32'(val);
    n_cfg++;
  endtask

  // One random operation; fill phases lean toward adding rows
  task automatic random_op(input bit fill);
    int                   pick;
    int                   len;
    int                   lenpick;
    logic [ROW_IDX_W-1:0] at;
    logic [COL_IDX_W-1:0] col;
    pick    = $urandom_range(0, 99);
    len     = cols_cfg;
    lenpick = $urandom_range(0, 99);
    if (lenpick < 8) len = cols_cfg + 1;
    else if (lenpick < 14 && cols_cfg > 1) len = cols_cfg - 1;
    else if (lenpick < 17 && cols_cfg == MAX_COLS) len = MAX_COLS + $urandom_range(1, 4);
    if (len < 1) len = 1;
    if (pick < (fill ? 55 : 20)) begin
      send_row(MODE_APPEND, len, 7'($urandom_range(0, MAX_ROWS)), $urandom_range(0, 5) == 0);
    end else if (pick < (fill ? 80 : 35)) begin
      if (row_total >= MAX_ROWS || $urandom_range(0, 9) > 0) at = 7'($urandom_range(0, row_total));
      else at = 7'($urandom_range(row_total + 1, MAX_ROWS));
      send_row(MODE_INSERT, len, at, $urandom_range(0, 5) == 0);
    end else if (pick < (fill ? 86 : 65)) begin
      if (row_total > 0 && $urandom_range(0, 99) < 85) at = 7'($urandom_range(0, row_total - 1));
      else at = 7'($urandom_range(row_total, MAX_ROWS));
      send_op(make_op(MODE_DELETE, at, 6'($urandom_range(0, MAX_COLS - 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))), 1'b0, '0);
    end else if (pick < (fill ? 95 : 90)) begin
      if (row_total > 0 && cols_cfg > 0 && $urandom_range(0, 99) < 80) begin
        at  = 7'($urandom_range(0, row_total - 1));
        col = 6'($urandom_range(0, cols_cfg - 1));
      end else begin
        at  = 7'($urandom_range(0, MAX_ROWS));
        col = 6'($urandom_range(0, MAX_COLS - 1));
      end
      send_op(make_op(MODE_READ, at, safe_col(at, col), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1))), 1'b0, '0);
    end else begin
      // noise: any mode, any fields
      at  = 7'($urandom_range(0, MAX_ROWS));
      col = 6'($urandom_range(0, MAX_COLS - 1));
      send_op(make_op(2'($urandom_range(0, 3)), at, safe_col(at, col),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))), 1'b0, '0);
    end
  endtask

  task automatic random_ops(input int budget, input bit fill);
    int stop_at;
    stop_at = n_items + budget;
    while (n_items < stop_at) random_op(fill);
  endtask

  task automatic new_phase(input logic [COLS_W-1:0] cols);
    wait_idle();
    write_cols(cols);
    tx_idle_on = $urandom_range(0, 3) > 0;
    rx_idle_on = $urandom_range(0, 3) > 0;
  endtask

  // Result receiver: random stalls, one long hold on request
  initial begin : result_sink
    int n;
    m_tready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        n        = HOLD_CYCLES;
        hold_req = 1'b0;
        n_holds++;
      end else begin
        n = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    table_res_t got;
    table_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.rd     = m_tdata[9:2];
      got.rows   = m_tdata[16:10];
      n_results++;
      if (result_q.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = result_q.pop_front();
        if (got.status !== want.status) note_mismatch("status", want, got);
        else if (got.rd !== want.rd) note_mismatch("read_char", want, got);
        else if (got.rows !== want.rows) note_mismatch("rows_in_use", want, got);
        if (want.status == STAT_DONE) n_done++;
        else if (want.status == STAT_REJECT) n_reject++;
        else n_staged++;
      end
    end
  end

  // Watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: no item moved for %0d cycles", quiet_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    int         k;
    table_op_t  op;
    table_res_t want;
    rst        <= 1'b1;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    s_tvalid   <= 1'b0;
    cfg_data   <= '0;
    cfg_valid  <= 1'b0;
    row_total   = 0;
    staged_len  = 0;
    cols_cfg    = 32'(COLS_RESET);
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    hold_req    = 1'b0;
    err_count   = 0;
    n_items     = 0;
    n_results   = 0;
    n_done      = 0;
    n_reject    = 0;
    n_staged    = 0;
    n_cfg       = 0;
    n_holds     = 0;
    peak_rows   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (k = 0; k < N_DIR; k++) begin
      if (dir_tab[k].is_cfg) begin
        wait_idle();
        write_cols(dir_tab[k].cfg_val);
      end else begin
        op          = make_op(dir_tab[k].mode, dir_tab[k].row, dir_tab[k].col,
                              dir_tab[k].ch, dir_tab[k].last);
        want.status = dir_tab[k].st;
        want.rd     = dir_tab[k].rd;
        want.rows   = dir_tab[k].rows;
        send_op(op, dir_tab[k].typed, want);
      end
    end

    // one-char rows, fill ends on an insert at row 0; two more adds are rejected
    new_phase(7'd1);
    random_ops(80, 1'b1);
    while (row_total < MAX_ROWS - 1) send_row(MODE_APPEND, 1, '0, 1'b0);
    while (row_total < MAX_ROWS) send_row(MODE_INSERT, 1, '0, 1'b0);
    send_row(MODE_APPEND, 1, '0, 1'b0);
    send_row(MODE_INSERT, 1, 7'd10, 1'b0);

    // two-character rows, drain; delete of row 0 moves the whole table
    new_phase(7'd2);
    send_op(make_op(MODE_DELETE, '0, '0, '0, 1'b0), 1'b0, '0);
    random_ops(70, 1'b0);

    // full-width rows, no idling on either side; one overlong row first
    new_phase(COLS_RESET);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_row(MODE_APPEND, MAX_COLS + 4, '0, 1'b0);
    send_row(MODE_APPEND, MAX_COLS, '0, 1'b1);
    random_ops(130, 1'b1);

    // three-character rows with a full drain halfway
    new_phase(7'd3);
    random_ops(40, 1'b1);
    wait_idle();
    random_ops(40, 1'b1);

    // short random width while the receiver holds off for a long stretch
    new_phase(7'($urandom_range(1, 8)));
    hold_req = 1'b1;
    random_ops(80, 1'b0);

    new_phase(7'd1);
    random_ops(70, 1'b1);

    // drain and settle
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d items sent, %0d results checked (%0d done, %0d rejected, %0d staged)",
             n_items, n_results, n_done, n_reject, n_staged);
    $display("tb: %0d column count writes, table peaked at %0d rows, %0d long output hold",
             n_cfg, peak_rows, n_holds);
    if (err_count == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
